// ----- rtl/packet_deframer_fletcher_check_macros.svh -----
// Assertion macros for the packet deframer with Fletcher-16 check.
// Used by packet_deframer_fletcher_check.sv; no other dependencies.
`ifndef PACKET_DEFRAMER_FLETCHER_CHECK_MACROS_SVH
`define PACKET_DEFRAMER_FLETCHER_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PDFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PDFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pdfc_pkg.sv -----
// Types, constants and the Fletcher-16 helper for the packet deframer.
// No dependencies; imported by packet_deframer_fletcher_check.
package pdfc_pkg;

    localparam int unsigned MAX_DATA_DEF = 1024;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned STAMP_W = 64;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned OUT_TDATA_W = 120;

    localparam logic [3:0]         STAMP_CNT_MASK = 4'hF;
    localparam logic [COUNT_W-1:0] STAMP_MAX_BYTES = 16'd8;

    typedef enum logic [8:0] {
        PH_TYPE  = 9'b000000001,
        PH_FLAGS = 9'b000000010,
        PH_STAMP = 9'b000000100,
        PH_LENH  = 9'b000001000,
        PH_LENL  = 9'b000010000,
        PH_DATA  = 9'b000100000,
        PH_CHKH  = 9'b001000000,
        PH_CHKL  = 9'b010000000,
        PH_DONE  = 9'b100000000
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_LEN_OVER = 2'd3
    } t_status;

    // Expected check word from the running sums: {c0 - c1, c1 - 2*c0}, mod 256 each.
    function automatic logic [15:0] f_fletcher_expect(input logic [7:0] c0,
                                                      input logic [7:0] c1);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = c0 - c1;
        lo = c1 - {c0[6:0], 1'b0};
        return {hi, lo};
    endfunction

endpackage

// ----- rtl/packet_deframer_fletcher_check.sv -----
// Path: an input transfer is held in the input register, then in the result register, before it reaches m_axis.
// Throughput: one byte per cycle while the result register is not stalled; a byte with no result still takes a step.
// Each step is the phase update plus one 8-bit Fletcher add pair.
// Back-pressure: the input register holds while the result register is full and not taken.
// Reset: synchronous, active low; clears the phase, counter, header fields, sums, check word and both valid flags.
// Depends on pdfc_pkg and packet_deframer_fletcher_check_macros.svh.
`include "packet_deframer_fletcher_check_macros.svh"

module packet_deframer_fletcher_check
    import pdfc_pkg::*;
#(
    parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] in_byte
    input  logic                   s_axis_tlast,  // end_of_packet
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] data_byte, [17:8] data_index, [25:18] packet_type, [33:26] packet_flags,
    // [97:34] time_stamp, [113:98] data_length, [115:114] status, [119:116] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]             m_axis_tuser   // kind: 0 payload byte, 1 summary
);

    // Limit widened by one bit so a length of 65535 compares correctly
    localparam logic [COUNT_W:0] MAX_DATA_W = (COUNT_W + 1)'(MAX_DATA);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              advance;   // stage two may move on this cycle
    logic              step;      // a byte is processed this cycle

    // ---------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------
    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0]  r_type, n_type;
    logic [BYTE_W-1:0]  r_flags, n_flags;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [LEN_W-1:0]   r_length, n_length;
    logic [7:0]         r_sum_low, n_sum_low;
    logic [7:0]         r_sum_high, n_sum_high;
    logic [15:0]        r_check, n_check;

    logic               do_sum;
    logic               n_emit;
    logic [15:0]        expect_word;
    logic               len_over;
    t_status            n_status;

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   load_out;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step          = r_in_valid && advance;
    assign load_out      = step && (r_in_last || n_emit);

    // Next parse state for the byte held in the input register
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_type     = r_type;
        n_flags    = r_flags;
        n_stamp    = r_stamp;
        n_length   = r_length;
        n_check    = r_check;
        do_sum     = 1'b0;
        n_emit     = 1'b0;

        unique case (r_phase)
            PH_TYPE: begin
                n_type  = r_in_byte;
                do_sum  = 1'b1;
                n_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                n_flags = r_in_byte;
                do_sum  = 1'b1;
                n_count = '0;
                n_phase = ((r_in_byte[3:0] & STAMP_CNT_MASK) == 4'd0) ? PH_LENH : PH_STAMP;
            end
            PH_STAMP: begin
                // bytes past the eighth are summed only
                if (r_count < STAMP_MAX_BYTES) begin
                    n_stamp = r_stamp | (STAMP_W'(r_in_byte) << {r_count[2:0], 3'b000});
                end
                do_sum  = 1'b1;
                n_count = r_count + 1'b1;
                if (n_count >= {12'd0, r_flags[3:0] & STAMP_CNT_MASK}) begin
                    n_phase = PH_LENH;
                end
            end
            PH_LENH: begin
                n_length = {r_in_byte, 8'h00};
                do_sum   = 1'b1;
                n_phase  = PH_LENL;
            end
            PH_LENL: begin
                n_length = {r_length[15:8], r_in_byte};
                do_sum   = 1'b1;
                n_count  = '0;
                n_phase  = ({r_length[15:8], r_in_byte} == '0) ? PH_CHKH : PH_DATA;
            end
            PH_DATA: begin
                do_sum  = 1'b1;
                n_emit  = ({1'b0, r_count} < MAX_DATA_W);
                n_count = r_count + 1'b1;
                if (n_count >= r_length) begin
                    n_phase = PH_CHKH;
                end
            end
            PH_CHKH: begin
                n_check = {r_in_byte, 8'h00};
                n_phase = PH_CHKL;
            end
            PH_CHKL: begin
                n_check = {r_check[15:8], r_in_byte};
                n_phase = PH_DONE;
            end
            PH_DONE: begin
                n_phase = PH_DONE;   // trailing bytes ignored
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // Fletcher-16 running sums, mod 256
        n_sum_low  = do_sum ? (r_sum_low + r_in_byte) : r_sum_low;
        n_sum_high = do_sum ? (r_sum_high + n_sum_low) : r_sum_high;
    end

    // Summary status; length over limit wins over truncation and checksum
    always_comb begin
        expect_word = f_fletcher_expect(n_sum_low, n_sum_high);
        len_over = ((n_phase == PH_DATA) || (n_phase == PH_CHKH) ||
                    (n_phase == PH_CHKL) || (n_phase == PH_DONE)) &&
                   ({1'b0, n_length} > MAX_DATA_W);
        if (len_over) begin
            n_status = ST_LEN_OVER;
        end else if (n_phase != PH_DONE) begin
            n_status = ST_TRUNC;
        end else if (n_check != expect_word) begin
            n_status = ST_CHECKSUM;
        end else begin
            n_status = ST_OK;
        end
    end

    // Control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_TYPE;
            r_count     <= '0;
            r_type      <= '0;
            r_flags     <= '0;
            r_stamp     <= '0;
            r_length    <= '0;
            r_sum_low   <= '0;
            r_sum_high  <= '0;
            r_check     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
            if (step) begin
                if (r_in_last) begin
                    // packet closed: back to reset values
                    r_phase    <= PH_TYPE;
                    r_count    <= '0;
                    r_type     <= '0;
                    r_flags    <= '0;
                    r_stamp    <= '0;
                    r_length   <= '0;
                    r_sum_low  <= '0;
                    r_sum_high <= '0;
                    r_check    <= '0;
                end else begin
                    r_phase    <= n_phase;
                    r_count    <= n_count;
                    r_type     <= n_type;
                    r_flags    <= n_flags;
                    r_stamp    <= n_stamp;
                    r_length   <= n_length;
                    r_sum_low  <= n_sum_low;
                    r_sum_high <= n_sum_high;
                    r_check    <= n_check;
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (load_out) begin
            r_out_kind <= r_in_last;
            if (r_in_last) begin
                r_out_data <= {4'd0, n_status, n_length, n_stamp, n_flags, n_type,
                               {INDEX_W{1'b0}}, {BYTE_W{1'b0}}};
            end else begin
                r_out_data <= {4'd0, {STAT_W{1'b0}}, {LEN_W{1'b0}}, {STAMP_W{1'b0}},
                               {BYTE_W{1'b0}}, {BYTE_W{1'b0}},
                               r_count[INDEX_W-1:0], r_in_byte};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PDFC_ASSERT_NEXT(a_summary_clears, i_clk, i_rst_n,
        step && r_in_last,
        (r_phase == PH_TYPE) && (r_sum_low == 8'd0) && (r_sum_high == 8'd0),
        "state not cleared after packet summary")

    `PDFC_ASSERT_NOW(a_payload_in_data, i_clk, i_rst_n,
        load_out && !r_in_last,
        r_phase == PH_DATA,
        "payload transfer produced outside the data field")

    `PDFC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n,
        r_in_valid && !advance,
        r_in_valid && $stable(r_in_byte) && $stable(r_in_last),
        "input register lost a byte while stalled")

    `PDFC_ASSERT_NOW(a_payload_fields_zero, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == 1'b0),
        m_axis_tdata[OUT_TDATA_W-1:BYTE_W+INDEX_W] == '0,
        "payload transfer carries summary fields")

endmodule
